FILE: rtl/ansi_pkg.sv
// Shared constants and controller/datapath interface types for the ANSI escape stripper.
package ansi_pkg;

   localparam logic [7:0] NUL_CODE = 8'h00;
   localparam logic [7:0] BEL_CODE = 8'h07;
   localparam logic [7:0] ESC_CODE = 8'h1B;
   localparam logic [7:0] CSI_CODE = 8'h5B;
   localparam logic [7:0] ST_CODE  = 8'h5C;
   localparam logic [7:0] OSC_CODE = 8'h5D;
   localparam logic [7:0] FINAL_LO = 8'h40;
   localparam logic [7:0] FINAL_HI = 8'h7E;
   localparam logic [7:0] FE_HI    = 8'h5F;

   typedef struct packed {
      logic accept;
      logic rd_en;
      logic proc;
      logic flush_emit;
      logic tail_fail;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic sink_ready;
      logic q_empty;
      logic cnt_zero;
      logic acc_scan;
      logic acc_flush;
      logic tail_pending;
      logic pend_valid;
   } sts_type;

endpackage

FILE: rtl/ansi_ram.sv
// Generic single-port-write, registered-read RAM.
module ansi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ansi_ctrl.sv
// Sequencing state machine for the ANSI escape stripper.
module ansi_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  ansi_pkg::sts_type sts,
   output ansi_pkg::cmd_type cmd,
   output logic             take_ok
);

   import ansi_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      SCAN_RD,
      SCAN_PROC,
      FLUSH_RD,
      FLUSH_EMIT,
      FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      take_ok  = 1'b0;
      case (state_ff)
         IDLE: begin
            take_ok = sts.out_free;
            if (req_valid && sts.out_free) begin
               cmd.accept = 1'b1;
               if (sts.acc_flush) begin
                  state_in = FLUSH_RD;
               end else if (sts.acc_scan) begin
                  state_in = SCAN_RD;
               end
            end
         end
         SCAN_RD: begin
            if (!sts.q_empty) begin
               cmd.rd_en = 1'b1;
               state_in  = SCAN_PROC;
            end else if (sts.tail_pending) begin
               // drop the pending candidate at range end, rescan its tail
               if (sts.sink_ready) begin
                  cmd.tail_fail = 1'b1;
               end
            end else begin
               state_in = FINISH;
            end
         end
         SCAN_PROC: begin
            if (sts.sink_ready) begin
               cmd.proc = 1'b1;
               state_in = SCAN_RD;
            end
         end
         FLUSH_RD: begin
            if (!sts.cnt_zero) begin
               cmd.rd_en = 1'b1;
               state_in  = FLUSH_EMIT;
            end else begin
               state_in = FINISH;
            end
         end
         FLUSH_EMIT: begin
            if (sts.sink_ready) begin
               cmd.flush_emit = 1'b1;
               state_in       = FLUSH_RD;
            end
         end
         FINISH: begin
            if (!sts.pend_valid || sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/ansi_dp.sv
// Datapath: candidate tracking, byte classification, hold buffer and output stage.
module ansi_dp #(
   parameter int MAX_SEQ_LEN = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  ansi_pkg::cmd_type  cmd,
   output ansi_pkg::sts_type  sts,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic [7:0]        req_in_byte,
   input  logic              req_range_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_run_last
);

   import ansi_pkg::*;

   localparam int PTR_W = $clog2(MAX_SEQ_LEN);
   localparam int DEPTH = 1 << PTR_W;
   localparam int CNT_W = $clog2(MAX_SEQ_LEN + 1);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEQ_LEN);
   localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);

   typedef enum logic [2:0] {
      RES_EMIT,
      RES_START,
      RES_HOLD,
      RES_DONE,
      RES_FAIL
   } scan_res_type;

   function automatic scan_res_type scan_byte(input logic [7:0]       b,
                                              input logic [CNT_W-1:0] cnt,
                                              input logic [7:0]       kind,
                                              input logic [7:0]       prev);
      scan_res_type res;
      if (cnt == '0) begin
         res = (b == ESC_CODE) ? RES_START : RES_EMIT;
      end else if (cnt == CNT_ONE) begin
         if (b == CSI_CODE || b == OSC_CODE) begin
            res = RES_HOLD;
         end else if (b >= FINAL_LO && b <= FE_HI) begin
            res = RES_DONE;
         end else begin
            res = RES_FAIL;
         end
      end else if (b == NUL_CODE) begin
         res = RES_FAIL;
      end else if (kind == CSI_CODE && b >= FINAL_LO && b <= FINAL_HI) begin
         res = RES_DONE;
      end else if (kind == OSC_CODE &&
                   (b == BEL_CODE || (b == ST_CODE && prev == ESC_CODE))) begin
         res = RES_DONE;
      end else if (cnt + CNT_ONE == CNT_MAX) begin
         res = RES_FAIL;
      end else begin
         res = RES_HOLD;
      end
      return res;
   endfunction

   logic             pass_ff, pass_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] base_ff, base_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W-1:0] end_ff, end_in;
   logic [7:0]       kind_ff, kind_in;
   logic [7:0]       prev_ff, prev_in;
   logic             last_ff, last_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [7:0]       pend_byte_ff, pend_byte_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;

   logic [7:0]       rd_data;
   scan_res_type     res_req, res_mem, res;
   logic [7:0]       scan_b;
   logic [PTR_W-1:0] scan_pos;
   logic             scan_go;
   logic             out_free;
   logic             emit_v, emit_direct;
   logic [7:0]       emit_b;

   ansi_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (cmd.accept),
      .wr_addr(end_ff),
      .wr_data(req_in_byte),
      .rd_en  (cmd.rd_en),
      .rd_addr(rd_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      res_req  = scan_byte(req_in_byte, count_ff, kind_ff, prev_ff);
      res_mem  = scan_byte(rd_data, count_ff, kind_ff, prev_ff);
      res      = cmd.proc ? res_mem : res_req;
      scan_b   = cmd.proc ? rd_data : req_in_byte;
      scan_pos = cmd.proc ? rd_ff : end_ff;
      scan_go  = (cmd.accept && !pass_ff) || cmd.proc;
      out_free = !out_valid_ff || !rsp_stall;

      sts.out_free     = out_free;
      sts.sink_ready   = !pend_valid_ff || out_free;
      sts.q_empty      = (rd_ff == end_ff);
      sts.cnt_zero     = (count_ff == '0);
      sts.acc_flush    = pass_ff && (count_ff != '0);
      sts.acc_scan     = !pass_ff && (res_req == RES_FAIL ||
                         (req_range_last && (res_req == RES_START || res_req == RES_HOLD)));
      sts.tail_pending = last_ff && (count_ff != '0);
      sts.pend_valid   = pend_valid_ff;
   end

   // pick the byte leaving this cycle, if any
   always_comb begin
      emit_v      = 1'b0;
      emit_direct = 1'b0;
      emit_b      = scan_b;
      if (scan_go) begin
         case (res)
            RES_EMIT: begin
               emit_v      = 1'b1;
               emit_direct = cmd.accept;
            end
            RES_FAIL: begin
               emit_v = 1'b1;
               emit_b = ESC_CODE;
            end
            default: begin
            end
         endcase
      end
      if (cmd.accept && pass_ff && count_ff == '0) begin
         emit_v      = 1'b1;
         emit_direct = 1'b1;
         emit_b      = req_in_byte;
      end
      if (cmd.flush_emit) begin
         emit_v = 1'b1;
         emit_b = rd_data;
      end
      if (cmd.tail_fail) begin
         emit_v = 1'b1;
         emit_b = ESC_CODE;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      if (emit_direct) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_b;
         out_last_in  = 1'b1;
      end else if (emit_v) begin
         // advance the held result; it is not the last one
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_byte_in  = pend_byte_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_byte_in  = emit_b;
      end
      if (cmd.finish && pend_valid_ff) begin
         out_valid_in  = 1'b1;
         out_byte_in   = pend_byte_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      pass_in  = csr_wr_en ? csr_wr_data : pass_ff;
      count_in = count_ff;
      base_in  = base_ff;
      rd_in    = rd_ff;
      end_in   = end_ff;
      kind_in  = kind_ff;
      prev_in  = prev_ff;
      last_in  = last_ff;
      if (cmd.accept) begin
         end_in  = end_ff + PTR_ONE;
         rd_in   = end_ff + PTR_ONE;
         last_in = req_range_last;
         if (pass_ff && count_ff != '0) begin
            count_in = count_ff + CNT_ONE;
            rd_in    = base_ff;
         end
      end
      if (cmd.proc) begin
         rd_in = rd_ff + PTR_ONE;
      end
      if (scan_go) begin
         case (res)
            RES_START: begin
               base_in  = scan_pos;
               count_in = CNT_ONE;
               prev_in  = scan_b;
            end
            RES_HOLD: begin
               count_in = count_ff + CNT_ONE;
               prev_in  = scan_b;
               if (count_ff == CNT_ONE) begin
                  kind_in = scan_b;
               end
            end
            RES_DONE: begin
               count_in = '0;
            end
            RES_FAIL: begin
               count_in = '0;
               rd_in    = base_ff + PTR_ONE;
            end
            default: begin
            end
         endcase
      end
      if (cmd.flush_emit) begin
         count_in = count_ff - CNT_ONE;
         rd_in    = rd_ff + PTR_ONE;
      end
      if (cmd.tail_fail) begin
         count_in = '0;
         rd_in    = base_ff + PTR_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff       <= 1'b0;
         count_ff      <= '0;
         rd_ff         <= '0;
         end_ff        <= '0;
         last_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pass_ff       <= pass_in;
         count_ff      <= count_in;
         rd_ff         <= rd_in;
         end_ff        <= end_in;
         last_ff       <= last_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      base_ff      <= base_in;
      kind_ff      <= kind_in;
      prev_ff      <= prev_in;
      pend_byte_ff <= pend_byte_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = out_last_ff;

endmodule

FILE: rtl/ansi_escape_stripper.sv
// Top level of the ANSI escape stripper: controller, datapath and checks.
//
// Removes complete CSI, OSC and two-byte ESC sequences from a byte range, or copies
// every byte when pass-through is set. A request whose byte is emitted directly or
// taken into an escape candidate leaves the controller idle, and the next request
// can be taken in the following cycle provided the result register drains. When a
// candidate fails (bad byte, NUL, overlong, or cut off by the range end) its ESC is
// released and the held bytes are decoded again out of the hold RAM, each by a
// registered read and then a decode; once the hold is empty the final result of the
// request is released. A candidate cut off by the range end releases its ESC once
// the hold is empty. Turning pass-through on while bytes are held makes the next
// request flush each held byte and the new one (registered read, then emit) first.
// The hold RAM needs no clearing after reset.
module ansi_escape_stripper #(
   parameter int MAX_SEQ_LEN = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_range_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   import ansi_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    take_ok;

   ansi_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .sts      (sts),
      .cmd      (cmd),
      .take_ok  (take_ok)
   );

   ansi_dp #(
      .MAX_SEQ_LEN(MAX_SEQ_LEN)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_in_byte   (req_in_byte),
      .req_range_last(req_range_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last)
   );

   assign req_stall = !take_ok;

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.rd_en, cmd.proc, cmd.flush_emit, cmd.tail_fail, cmd.finish}))
      else $error("controller issued more than one command");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.proc || cmd.flush_emit || cmd.tail_fail) |-> sts.sink_ready)
      else $error("byte released with no room in the output stage");

   a_rescan_blocks: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && sts.acc_scan) |=> req_stall)
      else $error("request taken while a rescan is in progress");

   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && sts.pend_valid) |=> (rsp_valid && rsp_run_last))
      else $error("final result of a request not marked last");

endmodule
